// File: sv/eehd_pkg.sv
package eehd_pkg;

  // default widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ENV_BITS_DEF    = 24;

  // register file layout
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam int ALPHA_BITS = 16;

  localparam logic [1:0] REG_ALPHA   = 2'd0;
  localparam logic [1:0] REG_ON_THR  = 2'd1;
  localparam logic [1:0] REG_OFF_THR = 2'd2;

  // register reset values
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET   = 16'd62259;
  localparam logic [31:0]           ON_THR_RESET  = 32'd3355443;
  localparam logic [31:0]           OFF_THR_RESET = 32'd1677722;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

endpackage

// File: sv/eehd_mul.sv
module eehd_mul
  import eehd_pkg::*;
#(
  parameter int MUL_BITS = 32
) (
  input  logic                    clk,
  input  logic [MUL_BITS-1:0]     op_a,
  input  logic [MUL_BITS-1:0]     op_b,
  output logic [2*MUL_BITS-1:0]   prod
);

  // shared unsigned multiplier, product registered every cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// File: sv/eehd_regs.sv
module eehd_regs
  import eehd_pkg::*;
#(
  parameter int ENV_BITS = ENV_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic [ALPHA_BITS-1:0] alpha,
  output logic [ENV_BITS-1:0]   on_thr,
  output logic [ENV_BITS-1:0]   off_thr
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign wr_en   = psel & penable & pwrite;

  // register writes, values masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha   <= ALPHA_RESET;
      on_thr  <= ON_THR_RESET[ENV_BITS-1:0];
      off_thr <= OFF_THR_RESET[ENV_BITS-1:0];
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALPHA:   alpha   <= pwdata[ALPHA_BITS-1:0];
        REG_ON_THR:  on_thr  <= pwdata[ENV_BITS-1:0];
        REG_OFF_THR: off_thr <= pwdata[ENV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_ALPHA:   prdata = DATA_BITS'(alpha);
      REG_ON_THR:  prdata = DATA_BITS'(on_thr);
      REG_OFF_THR: prdata = DATA_BITS'(off_thr);
      default:     prdata = '0;
    endcase
  end

endmodule

// File: sv/energy_envelope_hysteresis_detector.sv
// each input beat steps through S_SQ, S_SAT, S_MA and S_MB before the output beat is loaded
// a new sample is taken only in S_IDLE, after the last one is done; the single shared
//   multiplier is used three times per sample (square, alpha*env, (1-alpha)*square)
// a stalled output holds the sequencer in its last step until the beat is taken
// reset (rst, synchronous) clears envelope and detection state and loads
//   the register defaults; no clearing pass is needed
module energy_envelope_hysteresis_detector
  import eehd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ENV_BITS    = ENV_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + ENV_BITS + 3 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // sample_in
  // master stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // sample_out, envelope, event_res, active
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int MW0      = (SAMPLE_BITS > ENV_BITS) ? SAMPLE_BITS : ENV_BITS;
  localparam int MUL_BITS = (MW0 > ALPHA_BITS + 1) ? MW0 : ALPHA_BITS + 1;
  localparam int SHIFT    = 2 * (SAMPLE_BITS - 1) - ENV_BITS;
  localparam int SHR      = (SHIFT >= 0) ? SHIFT : 0;
  localparam int SHL      = (SHIFT < 0) ? -SHIFT : 0;
  localparam int SQ_W     = 2 * SAMPLE_BITS + ENV_BITS;
  localparam int ACC_W    = ENV_BITS + ALPHA_BITS + 1;
  localparam int PAD_W    = OUT_W - (SAMPLE_BITS + ENV_BITS + 3);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SAT, S_MA, S_MB} state_t;

  state_t                  state;
  logic [SAMPLE_BITS-1:0]  sample;
  logic [SAMPLE_BITS-1:0]  mag;
  logic [ENV_BITS-1:0]     x2;
  logic [ACC_W-1:0]        acc;
  logic [ENV_BITS-1:0]     energy_level;
  logic                    detect_on;

  logic [SAMPLE_BITS-1:0]  out_sample;
  logic [ENV_BITS-1:0]     out_env;
  logic [1:0]              out_event;
  logic                    out_active;

  logic [ALPHA_BITS-1:0]   alpha;
  logic [ENV_BITS-1:0]     on_thr;
  logic [ENV_BITS-1:0]     off_thr;

  logic [MUL_BITS-1:0]     op_a;
  logic [MUL_BITS-1:0]     op_b;
  logic [2*MUL_BITS-1:0]   prod;

  logic [SAMPLE_BITS-1:0]  in_sample;
  logic [SAMPLE_BITS-1:0]  in_mag;
  logic [SQ_W-1:0]         sq_shift;
  logic [ENV_BITS-1:0]     x2_sat;
  logic [ALPHA_BITS:0]     beta;
  logic [ACC_W-1:0]        sum;
  logic [ENV_BITS-1:0]     env_new;
  logic                    out_free;
  logic                    out_load;

  // register file
  eehd_regs #(
    .ENV_BITS (ENV_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .alpha   (alpha),
    .on_thr  (on_thr),
    .off_thr (off_thr)
  );

  assign pready = 1'b1;

  // shared multiplier
  eehd_mul #(
    .MUL_BITS (MUL_BITS)
  ) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // sample magnitude, most negative value gives 2^(SAMPLE_BITS-1)
  assign in_sample = s_tdata[SAMPLE_BITS-1:0];
  assign in_mag    = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;

  // square to Q0.ENV_BITS with saturation
  assign sq_shift = (SQ_W'(prod[2*SAMPLE_BITS-1:0]) << SHL) >> SHR;
  assign x2_sat   = (|sq_shift[SQ_W-1:ENV_BITS]) ? '1 : sq_shift[ENV_BITS-1:0];

  assign beta = (ALPHA_BITS + 1)'(1 << ALPHA_BITS) - (ALPHA_BITS + 1)'(alpha);

  // multiplier operand select per step
  always_comb begin
    unique case (state)
      S_SQ: begin
        op_a = MUL_BITS'(mag);
        op_b = MUL_BITS'(mag);
      end
      S_SAT: begin
        op_a = MUL_BITS'(alpha);
        op_b = MUL_BITS'(energy_level);
      end
      S_MA, S_MB: begin
        op_a = MUL_BITS'(beta);
        op_b = MUL_BITS'(x2);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // envelope sum and truncating shift
  assign sum     = acc + prod[ACC_W-1:0];
  assign env_new = sum[ENV_BITS+ALPHA_BITS-1:ALPHA_BITS];

  assign out_free = ~m_tvalid | m_tready;
  assign out_load = (state == S_MB) & out_free;
  assign s_tready = (state == S_IDLE);

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      energy_level <= '0;
      detect_on    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // output valid set on load, cleared once the beat is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sample <= in_sample;
            mag    <= in_mag;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_SAT;
        end
        S_SAT: begin
          x2    <= x2_sat;
          state <= S_MA;
        end
        S_MA: begin
          acc   <= prod[ACC_W-1:0];
          state <= S_MB;
        end
        S_MB: begin
          if (out_free) begin
            energy_level <= env_new;
            out_sample   <= sample;
            out_env      <= env_new;
            if (!detect_on && env_new >= on_thr) begin
              detect_on  <= 1'b1;
              out_active <= 1'b1;
              out_event  <= EV_START;
            end else if (detect_on && env_new <= off_thr) begin
              detect_on  <= 1'b0;
              out_active <= 1'b0;
              out_event  <= EV_STOP;
            end else begin
              out_active <= detect_on;
              out_event  <= EV_NONE;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output beat packing
  generate
    if (PAD_W > 0) begin : g_pad
      assign m_tdata = {{PAD_W{1'b0}}, out_active, out_event, out_env, out_sample};
    end else begin : g_nopad
      assign m_tdata = {out_active, out_event, out_env, out_sample};
    end
  endgenerate

  // a start event always leaves the detector active, a stop inactive
  a_event_active: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_event == EV_START) |-> out_active)
    else $error("start event without active state");

  a_stop_inactive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_event == EV_STOP) |-> !out_active)
    else $error("stop event with active state");

  // envelope only moves in the final step
  a_env_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_MB) |=> $stable(energy_level))
    else $error("envelope changed outside final step");

  // no new sample while one is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while busy");

endmodule

// File: tb/sv/energy_envelope_hysteresis_detector_tb.sv
module energy_envelope_hysteresis_detector_tb
  import eehd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = 16;
  localparam int OUT_W = 48;
  localparam logic [1:0] REG_SPARE = 2'd3;   // decodes to nothing
  localparam logic [15:0] SMP_MIN = 16'h8000;
  localparam logic [15:0] SMP_MAX = 16'h7FFF;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [15:0] sample;
    logic [23:0] envelope;
    logic [1:0]  event_code;
    logic        active;
  } det_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;    // sample_in
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // sample_out, envelope, event_res, active

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // detector state as the predictor sees it
  logic [15:0] cfg_alpha = ALPHA_RESET;
  logic [23:0] cfg_on    = ON_THR_RESET[23:0];
  logic [23:0] cfg_off   = OFF_THR_RESET[23:0];
  logic [23:0] env_level = '0;
  logic        det_active = 1'b0;

  logic [15:0] pending_samples[$];
  det_result_t predicted_results[$];

  int in_idle_pct  = 30;
  int out_idle_pct = 30;
  bit hold_req = 1'b0;
  logic hold_rx = 1'b0;

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int starts_seen = 0;
  int stops_seen = 0;
  int settings_used = 1;

  energy_envelope_hysteresis_detector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // square, fold into the envelope, then apply hysteresis
  function automatic det_result_t detector_update(input logic [15:0] smp);
    logic [16:0] mag;
    logic [33:0] sq;
    logic [33:0] sq_q24;
    logic [23:0] x2;
    logic [63:0] acc;
    det_result_t r;
    mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    sq = {17'd0, mag} * {17'd0, mag};
    sq_q24 = sq >> 6;
    x2 = (sq_q24 > 34'hFFFFFF) ? 24'hFFFFFF : sq_q24[23:0];
    acc = {48'd0, cfg_alpha} * {40'd0, env_level}
        + (64'd65536 - {48'd0, cfg_alpha}) * {40'd0, x2};
    env_level = acc[39:16];
    r.event_code = EV_NONE;
    if (!det_active && env_level >= cfg_on) begin
      det_active = 1'b1;
      r.event_code = EV_START;
    end else if (det_active && env_level <= cfg_off) begin
      det_active = 1'b0;
      r.event_code = EV_STOP;
    end
    r.sample = smp;
    r.envelope = env_level;
    r.active = det_active;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= 50)
      $display("mismatch at beat %0d: %s got 0x%0h expected 0x%0h", beats_out, what, got, want);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ALPHA:   cfg_alpha = value[15:0];
      REG_ON_THR:  cfg_on = value[23:0];
      REG_OFF_THR: cfg_off = value[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] a, input logic [23:0] on_thr,
                            input logic [23:0] off_thr);
    write_reg(REG_ALPHA, ($urandom() & 32'hFFFF0000) | {16'd0, a});
    write_reg(REG_ON_THR, ($urandom() & 32'hFF000000) | {8'd0, on_thr});
    write_reg(REG_OFF_THR, ($urandom() & 32'hFF000000) | {8'd0, off_thr});
    settings_used++;
  endtask

  // wait until every sample went in and every result came out
  task automatic drain_pipeline;
    while (pending_samples.size() != 0 || s_tvalid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // bursts of loud and quiet samples so the envelope crosses the thresholds
  task automatic queue_bursts(input int count);
    int n;
    int len;
    logic [15:0] smp;
    n = 0;
    while (n < count) begin
      len = $urandom_range(3, 40);
      for (int i = 0; i < len && n < count; i++) begin
        smp = 16'($urandom());
        if ($urandom_range(15) == 0) smp = SMP_MIN;
        pending_samples.push_back(smp);
        n++;
      end
      len = $urandom_range(3, 60);
      for (int i = 0; i < len && n < count; i++) begin
        smp = 16'($urandom_range(0, 1023));
        if ($urandom_range(1)) smp = -smp;
        pending_samples.push_back(smp);
        n++;
      end
    end
  endtask

  // sender: next sample once the current beat is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_samples.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_rx && ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // predict on input beats, check on output beats
  always @(posedge clk) begin : monitor
    det_result_t got;
    det_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted_results.push_back(detector_update(s_tdata[15:0]));
        beats_in++;
      end
      if (m_tvalid && m_tready) begin
        got.sample = m_tdata[15:0];
        got.envelope = m_tdata[39:16];
        got.event_code = m_tdata[41:40];
        got.active = m_tdata[42];
        beats_out++;
        if (got.event_code == EV_START) starts_seen++;
        if (got.event_code == EV_STOP) stops_seen++;
        if (predicted_results.size() == 0) begin
          flag_mismatch("unexpected beat, tdata", m_tdata[31:0], 32'd0);
        end else begin
          want = predicted_results.pop_front();
          if (got.sample != want.sample)
            flag_mismatch("sample_out", 32'(got.sample), 32'(want.sample));
          if (got.envelope != want.envelope)
            flag_mismatch("envelope", 32'(got.envelope), 32'(want.envelope));
          if (got.event_code != want.event_code)
            flag_mismatch("event_res", 32'(got.event_code), 32'(want.event_code));
          if (got.active != want.active)
            flag_mismatch("active", 32'(got.active), 32'(want.active));
        end
      end
    end
  end

  initial begin
    logic [23:0] on_thr;
    logic [23:0] off_thr;
    logic [15:0] a;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: field extremes, then a loud run to start detection
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(SMP_MAX);
    pending_samples.push_back(16'h5555);
    pending_samples.push_back(16'hAAAA);
    repeat (5) pending_samples.push_back(SMP_MIN);
    drain_pipeline();

    // no smoothing: envelope is the square, stop and start exactly on a threshold
    set_config(16'd0, 24'h400000, 24'h100000);
    pending_samples.push_back(SMP_MIN);
    pending_samples.push_back(16'h2000);
    pending_samples.push_back(16'h4000);
    pending_samples.push_back(16'h0000);
    drain_pipeline();

    // heaviest smoothing with overlapping thresholds: toggles every sample
    set_config(16'hFFFF, 24'h000000, 24'hFFFFFF);
    pending_samples.push_back(SMP_MAX);
    pending_samples.push_back(SMP_MIN);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'h1234);
    drain_pipeline();

    // saturated square against the top threshold; spare address is ignored
    set_config(16'd0, 24'hFFFFFF, 24'h000000);
    write_reg(REG_SPARE, $urandom());
    pending_samples.push_back(SMP_MIN);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(SMP_MAX);
    drain_pipeline();

    // random settings, bursty traffic
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(3))
        0: a = 16'($urandom_range(56000, 65535));
        1: a = 16'($urandom_range(0, 65535));
        2: a = 16'($urandom_range(0, 8000));
        default: a = (p % 2) ? 16'hFFFF : 16'h0000;
      endcase
      on_thr = 24'($urandom_range(24'h080000, 24'hC00000));
      if ($urandom_range(7) == 0)
        off_thr = 24'($urandom_range(on_thr, 24'hFFFFFF));
      else
        off_thr = 24'($urandom_range(0, on_thr));
      set_config(a, on_thr, off_thr);
      in_idle_pct = (p == 1) ? 0 : 30;
      out_idle_pct = (p == 1) ? 0 : 30;
      queue_bursts(PHASE_ITEMS);
      if (p == 3) hold_req = 1'b1;
      drain_pipeline();
    end

    $display("ran %0d samples through %0d register settings, %0d results checked",
             beats_in, settings_used, beats_out);
    $display("detection started %0d times and stopped %0d times", starts_seen, stops_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
